/* hdl/spu_pkg.sv */
// ----------------------------------------------------------------------------
// spu_pkg: shared types and constants of the sllod particle update
// fixed-point widths, payload structs, pipeline context and register indexes
// ----------------------------------------------------------------------------
package spu_pkg;

    // field widths
    localparam int VAL_W   = 32;               // signed Q16.16 values
    localparam int COEF_W  = 16;               // signed Q4.12 tensor coefficients
    localparam int ROW_W   = 3 * COEF_W;       // one packed tensor row
    localparam int MASS_W  = 16;               // unsigned Q8.8 mass
    localparam int DT_W    = 16;               // unsigned Q0.16 time step
    localparam int HDT_W   = 32;               // unsigned Q0.32 half step squared
    localparam int FRAC    = 12;               // coefficient fraction bits

    // internal widths
    localparam int DIFF_W  = VAL_W + 1;        // pos - ref, exact
    localparam int PROD_W  = COEF_W + DIFF_W;  // coefficient times component
    localparam int ACC_W   = PROD_W + 2;       // sum of three products
    localparam int SF_W    = ACC_W - FRAC;     // tensor result after scaling
    localparam int FP_W    = SF_W + MASS_W + 1;// shear term times mass
    localparam int NUM_W   = 64;               // dividend before shift
    localparam int QUO_W   = 40;               // dividend magnitude / quotient
    localparam int QS_W    = QUO_W + 1;        // signed quotient
    localparam int SUM_W   = 50;               // headroom for sums before clamp

    // divider shape
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    // shifts of the two divided terms, the drift term and the shear force
    localparam int POS_SHIFT = 24;
    localparam int VEL_SHIFT = 9;
    localparam int AT_SHIFT  = 16;
    localparam int FRC_SHIFT = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_ROW_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_ROW_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_ROW_Z       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_X             = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Y             = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_Z             = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP_SQUARED = 3'd7;

    localparam logic [DT_W-1:0]   DT_RESET   = 16'd655;
    localparam logic [HDT_W-1:0]  HDT_RESET  = 32'd214748;
    localparam logic [MASS_W-1:0] MASS_ONE   = 16'd1;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic [2:0][VAL_W-1:0]  vec_t;
    typedef logic [2:0][DIFF_W-1:0] diff_vec_t;
    typedef logic [2:0][ACC_W-1:0]  acc_vec_t;
    typedef logic [2:0][ROW_W-1:0]  tensor_t;

    typedef struct packed {
        logic              mode;
        logic              frozen;
        logic [MASS_W-1:0] mass;
        logic [VAL_W-1:0]  pos_x;
        logic [VAL_W-1:0]  pos_y;
        logic [VAL_W-1:0]  pos_z;
        logic [VAL_W-1:0]  vel_x;
        logic [VAL_W-1:0]  vel_y;
        logic [VAL_W-1:0]  vel_z;
        logic [VAL_W-1:0]  frc_x;
        logic [VAL_W-1:0]  frc_y;
        logic [VAL_W-1:0]  frc_z;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] new_pos_x;
        logic [VAL_W-1:0] new_pos_y;
        logic [VAL_W-1:0] new_pos_z;
        logic [VAL_W-1:0] new_vel_x;
        logic [VAL_W-1:0] new_vel_y;
        logic [VAL_W-1:0] new_vel_z;
        logic [VAL_W-1:0] new_frc_x;
        logic [VAL_W-1:0] new_frc_y;
        logic [VAL_W-1:0] new_frc_z;
    } out_item_t;

    // per-particle state that travels down the pipeline
    typedef struct packed {
        logic              mode;
        logic              frozen;
        logic [2:0]        neg;
        logic [MASS_W-1:0] mass;
        vec_t              pos;
        vec_t              vel;
        vec_t              frc;
        vec_t              aterm;
    } ctx_t;

    // clamp a wide signed sum to the value range
    function automatic logic [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] s);
        logic ovf;
        ovf = (s[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){1'b0}})
           && (s[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){1'b1}});
        if (ovf)
        begin
            return s[SUM_W-1] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

/* hdl/spu_tensor_mac.sv */
// ----------------------------------------------------------------------------
// spu_tensor_mac: shear tensor times vector
// two stages: nine coefficient products, then the three row sums
// ----------------------------------------------------------------------------
module spu_tensor_mac (
    input  logic               clk,
    input  logic               en,
    input  spu_pkg::tensor_t   rows,
    input  spu_pkg::diff_vec_t vec,
    output spu_pkg::acc_vec_t  acc
);

    logic signed [spu_pkg::PROD_W-1:0] prod_reg [3][3];
    spu_pkg::acc_vec_t                 acc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= $signed(rows[i][spu_pkg::COEF_W*j +: spu_pkg::COEF_W])
                                    * $signed(vec[j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= spu_pkg::ACC_W'(prod_reg[i][0])
                            + spu_pkg::ACC_W'(prod_reg[i][1])
                            + spu_pkg::ACC_W'(prod_reg[i][2]);
            end
        end
    end

    assign acc = acc_reg;

endmodule

/* hdl/spu_floor_div.sv */
// ----------------------------------------------------------------------------
// spu_floor_div: pipelined unsigned divider by the particle mass
// restoring division, a few quotient bits per stage
// ----------------------------------------------------------------------------
module spu_floor_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [spu_pkg::QUO_W-1:0]   num,
    input  logic [spu_pkg::MASS_W-1:0]  den,
    output logic [spu_pkg::QUO_W-1:0]   quo
);

    localparam int NS = spu_pkg::DIV_STAGES;

    // work holds remaining dividend bits on top, quotient bits fill from below
    logic [spu_pkg::QUO_W-1:0]  work_reg  [NS];
    logic [spu_pkg::MASS_W-1:0] rem_reg   [NS];
    logic [spu_pkg::MASS_W-1:0] den_reg   [NS];
    logic [spu_pkg::QUO_W-1:0]  work_next [NS];
    logic [spu_pkg::MASS_W-1:0] rem_next  [NS];
    logic [spu_pkg::MASS_W-1:0] den_src   [NS];

    always_comb
    begin
        logic [spu_pkg::QUO_W-1:0]  w;
        logic [spu_pkg::MASS_W-1:0] r;
        logic [spu_pkg::MASS_W-1:0] d;
        logic [spu_pkg::MASS_W:0]   trial;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                w = num;
                r = '0;
                d = den;
            end
            else
            begin
                w = work_reg[s-1];
                r = rem_reg[s-1];
                d = den_reg[s-1];
            end
            for (int b = 0; b < spu_pkg::DIV_BITS; b++)
            begin
                trial = {r, w[spu_pkg::QUO_W-1]};
                w     = {w[spu_pkg::QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, d})
                begin
                    trial = trial - {1'b0, d};
                    w[0]  = 1'b1;
                end
                r = trial[spu_pkg::MASS_W-1:0];
            end
            work_next[s] = w;
            rem_next[s]  = r;
            den_src[s]   = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                work_reg[s] <= work_next[s];
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_src[s];
            end
        end
    end

    assign quo = work_reg[NS-1];

endmodule

/* hdl/sllod_particle_update.sv */
// ----------------------------------------------------------------------------
// sllod_particle_update: shear-flow velocity verlet update of one particle
// position mode adds the shear velocity and shear force, then moves the
// particle; velocity mode adds the shear force, then kicks the velocity
// ----------------------------------------------------------------------------
//
//  channel   signals                          transfer when
//  -------   -------------------------------  ---------------------------
//  in        in_valid, in_ready, in_data      in_valid & in_ready
//  out       out_valid, out_ready, out_data   out_valid & out_ready
//  cfg       cfg_wr_en, cfg_index, cfg_data   cfg_wr_en (no wait)
//
//  one particle per cycle while out is not stalled
//  the pipeline holds the two tensor units and the 10-stage mass divider
//  every stage advances together; a result held on out stalls all stages,
//  so nothing is dropped or repeated while in_ready is low
//  reset clears valid bits, tensor and ref; dt, hdt get defaults; no clearing pass
//
module sllod_particle_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  spu_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output spu_pkg::out_item_t                out_data,
    input  logic                              cfg_wr_en,
    input  logic [spu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // stage numbers of the pipeline
    localparam int STG_DIFF   = 1;   // pos - ref
    localparam int STG_VEL    = 4;   // velocity plus shear velocity
    localparam int STG_ATERM  = 5;   // dt * v
    localparam int STG_SFM    = 7;   // shear force times mass
    localparam int STG_FRC    = 8;   // force update
    localparam int STG_NUM    = 9;   // dividend product
    localparam int STG_DIVIN  = 10;  // shifted dividend magnitude
    localparam int STG_OUT    = STG_DIVIN + spu_pkg::DIV_STAGES + 1;
    localparam int LAST       = STG_OUT;

    // ---------------- configuration registers ----------------
    spu_pkg::tensor_t          shear_reg;
    spu_pkg::vec_t             ref_reg;
    logic [spu_pkg::DT_W-1:0]  dt_reg;
    logic [spu_pkg::HDT_W-1:0] hdt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shear_reg <= '0;
            ref_reg   <= '0;
            dt_reg    <= spu_pkg::DT_RESET;
            hdt_reg   <= spu_pkg::HDT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                spu_pkg::REG_SHEAR_ROW_X:       shear_reg[0] <= cfg_data;
                spu_pkg::REG_SHEAR_ROW_Y:       shear_reg[1] <= cfg_data;
                spu_pkg::REG_SHEAR_ROW_Z:       shear_reg[2] <= cfg_data;
                spu_pkg::REG_REF_X:             ref_reg[0] <= cfg_data[spu_pkg::VAL_W-1:0];
                spu_pkg::REG_REF_Y:             ref_reg[1] <= cfg_data[spu_pkg::VAL_W-1:0];
                spu_pkg::REG_REF_Z:             ref_reg[2] <= cfg_data[spu_pkg::VAL_W-1:0];
                spu_pkg::REG_TIME_STEP:         dt_reg <= cfg_data[spu_pkg::DT_W-1:0];
                spu_pkg::REG_HALF_STEP_SQUARED: hdt_reg <= cfg_data[spu_pkg::HDT_W-1:0];
                default:                        ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [LAST:0] vld_reg;
    logic          en;

    // the whole pipe moves unless a finished result is waiting
    assign en       = !vld_reg[LAST] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    // ---------------- datapath ----------------
    spu_pkg::ctx_t ctx_reg  [LAST+1];
    spu_pkg::ctx_t ctx_next [LAST+1];

    spu_pkg::diff_vec_t                d_reg;
    spu_pkg::diff_vec_t                v_ext;
    spu_pkg::acc_vec_t                 acc_sv;
    spu_pkg::acc_vec_t                 acc_sf;
    logic signed [spu_pkg::FP_W-1:0]   sfm_reg [3];
    logic signed [spu_pkg::NUM_W-1:0]  num_reg [3];
    logic signed [spu_pkg::QS_W-1:0]   y_w     [3];
    logic [spu_pkg::QUO_W-1:0]         uy_reg  [3];
    logic [spu_pkg::QUO_W-1:0]         quo     [3];
    logic [spu_pkg::HDT_W-1:0]         scale;

    // term multiplier for the divided part: hdtsqr in position mode, dt otherwise
    assign scale = ctx_reg[STG_NUM-1].mode ? spu_pkg::HDT_W'(dt_reg) : hdt_reg;

    always_comb
    begin
        logic signed [spu_pkg::SUM_W-1:0] q;
        logic signed [spu_pkg::DT_W+spu_pkg::VAL_W:0] at;

        // stage 0: capture, zero mass counts as one lsb
        ctx_next[0].mode   = in_data.mode;
        ctx_next[0].frozen = in_data.frozen;
        ctx_next[0].neg    = '0;
        ctx_next[0].mass   = (in_data.mass == '0) ? spu_pkg::MASS_ONE : in_data.mass;
        ctx_next[0].pos    = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
        ctx_next[0].vel    = {in_data.vel_z, in_data.vel_y, in_data.vel_x};
        ctx_next[0].frc    = {in_data.frc_z, in_data.frc_y, in_data.frc_x};
        ctx_next[0].aterm  = '0;

        for (int s = 1; s <= LAST; s++)
        begin
            ctx_next[s] = ctx_reg[s-1];
        end

        for (int k = 0; k < 3; k++)
        begin
            // shear velocity, position mode only
            if (!ctx_reg[STG_VEL-1].mode && !ctx_reg[STG_VEL-1].frozen)
            begin
                ctx_next[STG_VEL].vel[k] = spu_pkg::sat_val(
                    spu_pkg::SUM_W'($signed(ctx_reg[STG_VEL-1].vel[k]))
                  + spu_pkg::SUM_W'($signed(acc_sv[k]) >>> spu_pkg::FRAC));
            end

            // drift term dt * v, floor
            at = $signed({1'b0, dt_reg}) * $signed(ctx_reg[STG_ATERM-1].vel[k]);
            ctx_next[STG_ATERM].aterm[k] =
                at[spu_pkg::AT_SHIFT +: spu_pkg::VAL_W];

            // force plus mass-scaled shear force
            if (!ctx_reg[STG_FRC-1].frozen)
            begin
                ctx_next[STG_FRC].frc[k] = spu_pkg::sat_val(
                    spu_pkg::SUM_W'($signed(ctx_reg[STG_FRC-1].frc[k]))
                  + spu_pkg::SUM_W'(sfm_reg[k] >>> spu_pkg::FRC_SHIFT));
            end

            // floor division is done on magnitudes: floor(y/m) = ~(~y/m) for y < 0
            y_w[k] = ctx_reg[STG_DIVIN-1].mode
                   ? spu_pkg::QS_W'(num_reg[k] >>> spu_pkg::VEL_SHIFT)
                   : spu_pkg::QS_W'(num_reg[k] >>> spu_pkg::POS_SHIFT);
            ctx_next[STG_DIVIN].neg[k] = y_w[k][spu_pkg::QS_W-1];

            // final add of the divided term
            q = ctx_reg[STG_OUT-1].neg[k]
              ? spu_pkg::SUM_W'($signed(~{1'b0, quo[k]}))
              : spu_pkg::SUM_W'($signed({1'b0, quo[k]}));
            if (!ctx_reg[STG_OUT-1].frozen)
            begin
                if (ctx_reg[STG_OUT-1].mode)
                begin
                    ctx_next[STG_OUT].vel[k] = spu_pkg::sat_val(
                        spu_pkg::SUM_W'($signed(ctx_reg[STG_OUT-1].vel[k])) + q);
                end
                else
                begin
                    ctx_next[STG_OUT].pos[k] = spu_pkg::sat_val(
                        spu_pkg::SUM_W'($signed(ctx_reg[STG_OUT-1].pos[k]))
                      + spu_pkg::SUM_W'($signed(ctx_reg[STG_OUT-1].aterm[k])) + q);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= LAST; s++)
            begin
                ctx_reg[s] <= ctx_next[s];
            end
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k]   <= spu_pkg::DIFF_W'($signed(ctx_reg[STG_DIFF-1].pos[k]))
                            - spu_pkg::DIFF_W'($signed(ref_reg[k]));
                sfm_reg[k] <= $signed(spu_pkg::SF_W'($signed(acc_sf[k]) >>> spu_pkg::FRAC))
                            * $signed({1'b0, ctx_reg[STG_SFM-1].mass});
                num_reg[k] <= $signed(ctx_reg[STG_NUM-1].frc[k]) * $signed({1'b0, scale});
                uy_reg[k]  <= y_w[k][spu_pkg::QS_W-1] ? ~y_w[k][spu_pkg::QUO_W-1:0]
                                                      : y_w[k][spu_pkg::QUO_W-1:0];
            end
        end
    end

    // shear velocity: T * (pos - ref), stages 2 and 3
    spu_tensor_mac u_mac_sv (
        .clk  (clk),
        .en   (en),
        .rows (shear_reg),
        .vec  (d_reg),
        .acc  (acc_sv)
    );

    // shear force: T * v, stages 5 and 6
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_ext[k] = spu_pkg::DIFF_W'($signed(ctx_reg[STG_VEL].vel[k]));
        end
    end

    spu_tensor_mac u_mac_sf (
        .clk  (clk),
        .en   (en),
        .rows (shear_reg),
        .vec  (v_ext),
        .acc  (acc_sf)
    );

    // division by mass, stages 11 to 20
    for (genvar k = 0; k < 3; k++)
    begin : g_div
        spu_floor_div u_div (
            .clk (clk),
            .en  (en),
            .num (uy_reg[k]),
            .den (ctx_reg[STG_DIVIN].mass),
            .quo (quo[k])
        );
    end

    // ---------------- result ----------------
    assign out_valid          = vld_reg[LAST];
    assign out_data.new_pos_x = ctx_reg[LAST].pos[0];
    assign out_data.new_pos_y = ctx_reg[LAST].pos[1];
    assign out_data.new_pos_z = ctx_reg[LAST].pos[2];
    assign out_data.new_vel_x = ctx_reg[LAST].vel[0];
    assign out_data.new_vel_y = ctx_reg[LAST].vel[1];
    assign out_data.new_vel_z = ctx_reg[LAST].vel[2];
    assign out_data.new_frc_x = ctx_reg[LAST].frc[0];
    assign out_data.new_frc_y = ctx_reg[LAST].frc[1];
    assign out_data.new_frc_z = ctx_reg[LAST].frc[2];

`ifndef ASSERT_OFF
    // a held result freezes every stage's valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // an input transfer always lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted particle missing from first stage");

    // the divisor seen by the divider is never zero
    a_mass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[STG_DIVIN] |-> ctx_reg[STG_DIVIN].mass != '0)
        else $error("zero divisor reached the divider");
`endif

endmodule

/* bench/tb_sllod_particle_update.sv */
// ----------------------------------------------------------------------------
// tb_sllod_particle_update: self-checking bench of the sllod particle update
// drives particles through the valid/ready input, predicts each result with
// an independent fixed-point model and compares every field on the output
// ----------------------------------------------------------------------------
module tb_sllod_particle_update;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 22;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    spu_pkg::in_item_t              in_data;
    logic                           out_valid;
    logic                           out_ready;
    spu_pkg::out_item_t             out_data;
    logic                           cfg_wr_en;
    logic [spu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [spu_pkg::CFG_DATA_W-1:0] cfg_data;

    sllod_particle_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the configuration registers
    logic [spu_pkg::ROW_W-1:0] tensor_rows [3];
    logic signed [63:0]        wall_ref [3];
    logic [spu_pkg::DT_W-1:0]  dt_reg;
    logic [spu_pkg::HDT_W-1:0] hdt_reg;

    spu_pkg::out_item_t expected_results [$];
    int        mismatches;
    int        results_seen;
    int        particles_sent;
    int        send_gap_pct;    // sender idle chance in percent
    int        recv_gap_pct;    // receiver idle chance in percent
    int        hold_cycles;     // long receiver hold-off, counted below

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // fixed-point helpers: floor shift, floor divide, clamp
    // ------------------------------------------------------------------------
    function automatic logic signed [63:0] floor_div(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
        logic signed [63:0] q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic signed [63:0] clamp_q16(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // tensor times vector, floor of the 2^12 scaling
    function automatic void shear_apply(input logic signed [63:0] vin [3],
                                        output logic signed [63:0] vout [3]);
        logic signed [63:0] acc;
        logic signed [15:0] c;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                c   = tensor_rows[i][16*j +: 16];
                acc = acc + 64'(c) * vin[j];
            end
            vout[i] = acc >>> spu_pkg::FRAC;
        end
    endfunction

    // expected result of one particle under the current registers
    function automatic spu_pkg::out_item_t predict_update(input spu_pkg::in_item_t it);
        logic signed [63:0] p [3];
        logic signed [63:0] v [3];
        logic signed [63:0] f [3];
        logic signed [63:0] d [3];
        logic signed [63:0] t [3];
        logic signed [63:0] m;
        logic signed [63:0] a;
        logic signed [63:0] b;
        spu_pkg::out_item_t r;
        m = (it.mass == 0) ? 64'sd1 : 64'(it.mass);
        p[0] = 64'(signed'(it.pos_x)); p[1] = 64'(signed'(it.pos_y));
        p[2] = 64'(signed'(it.pos_z));
        v[0] = 64'(signed'(it.vel_x)); v[1] = 64'(signed'(it.vel_y));
        v[2] = 64'(signed'(it.vel_z));
        f[0] = 64'(signed'(it.frc_x)); f[1] = 64'(signed'(it.frc_y));
        f[2] = 64'(signed'(it.frc_z));
        if (!it.frozen)
        begin
            if (!it.mode)
            begin
                // shear velocity from the offset to the wall
                for (int i = 0; i < 3; i++)
                begin
                    d[i] = p[i] - wall_ref[i];
                end
                shear_apply(d, t);
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = clamp_q16(v[i] + t[i]);
                end
                shear_apply(v, t);
                for (int i = 0; i < 3; i++)
                begin
                    f[i] = clamp_q16(f[i] + ((t[i] * m) >>> spu_pkg::FRC_SHIFT));
                end
                for (int i = 0; i < 3; i++)
                begin
                    a    = (signed'(64'(dt_reg)) * v[i]) >>> spu_pkg::AT_SHIFT;
                    b    = floor_div(64'(hdt_reg) * f[i], m <<< spu_pkg::POS_SHIFT);
                    p[i] = clamp_q16(p[i] + a + b);
                end
            end
            else
            begin
                shear_apply(v, t);
                for (int i = 0; i < 3; i++)
                begin
                    f[i] = clamp_q16(f[i] + ((t[i] * m) >>> spu_pkg::FRC_SHIFT));
                    v[i] = clamp_q16(v[i] + floor_div(64'(dt_reg) * f[i],
                                                      m <<< spu_pkg::VEL_SHIFT));
                end
            end
        end
        r.new_pos_x = p[0][31:0]; r.new_pos_y = p[1][31:0]; r.new_pos_z = p[2][31:0];
        r.new_vel_x = v[0][31:0]; r.new_vel_y = v[1][31:0]; r.new_vel_z = v[2][31:0];
        r.new_frc_x = f[0][31:0]; r.new_frc_y = f[1][31:0]; r.new_frc_z = f[2][31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 results_seen);
    endtask

    // ------------------------------------------------------------------------
    // result checker: sample at the rising edge, compare with the oldest
    // expectation field by field
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        spu_pkg::out_item_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", out_data.new_pos_x, 32'h0);
            end
            else
            begin
                w = expected_results.pop_front();
                if (out_data.new_pos_x !== w.new_pos_x)
                    report_mismatch("new_pos_x", out_data.new_pos_x, w.new_pos_x);
                if (out_data.new_pos_y !== w.new_pos_y)
                    report_mismatch("new_pos_y", out_data.new_pos_y, w.new_pos_y);
                if (out_data.new_pos_z !== w.new_pos_z)
                    report_mismatch("new_pos_z", out_data.new_pos_z, w.new_pos_z);
                if (out_data.new_vel_x !== w.new_vel_x)
                    report_mismatch("new_vel_x", out_data.new_vel_x, w.new_vel_x);
                if (out_data.new_vel_y !== w.new_vel_y)
                    report_mismatch("new_vel_y", out_data.new_vel_y, w.new_vel_y);
                if (out_data.new_vel_z !== w.new_vel_z)
                    report_mismatch("new_vel_z", out_data.new_vel_z, w.new_vel_z);
                if (out_data.new_frc_x !== w.new_frc_x)
                    report_mismatch("new_frc_x", out_data.new_frc_x, w.new_frc_x);
                if (out_data.new_frc_y !== w.new_frc_y)
                    report_mismatch("new_frc_y", out_data.new_frc_y, w.new_frc_y);
                if (out_data.new_frc_z !== w.new_frc_z)
                    report_mismatch("new_frc_z", out_data.new_frc_z, w.new_frc_z);
            end
            results_seen++;
        end
    end

    // receiver: random back-pressure, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [spu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spu_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            spu_pkg::REG_SHEAR_ROW_X:       tensor_rows[0] = val;
            spu_pkg::REG_SHEAR_ROW_Y:       tensor_rows[1] = val;
            spu_pkg::REG_SHEAR_ROW_Z:       tensor_rows[2] = val;
            spu_pkg::REG_REF_X:             wall_ref[0] = 64'(signed'(val[31:0]));
            spu_pkg::REG_REF_Y:             wall_ref[1] = 64'(signed'(val[31:0]));
            spu_pkg::REG_REF_Z:             wall_ref[2] = 64'(signed'(val[31:0]));
            spu_pkg::REG_TIME_STEP:         dt_reg = val[spu_pkg::DT_W-1:0];
            spu_pkg::REG_HALF_STEP_SQUARED: hdt_reg = val[spu_pkg::HDT_W-1:0];
            default: ;
        endcase
    endtask

    // offer one particle, starting at a falling edge; valid stays up until
    // the transfer, and is only lowered if the sender then takes a gap
    task automatic send_particle(input spu_pkg::in_item_t it);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        expected_results.push_back(predict_update(it));
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        particles_sent++;
        @(negedge clk);
    endtask

    // lower valid and wait until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(255) - 128;
            3: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic spu_pkg::in_item_t rand_particle();
        spu_pkg::in_item_t it;
        it.mode   = 1'($urandom_range(1));
        it.frozen = ($urandom_range(9) == 0);
        case ($urandom_range(4))
            0: it.mass = 16'd1;
            1: it.mass = 16'hffff;
            2: it.mass = 16'd0;
            default: it.mass = 16'($urandom);
        endcase
        it.pos_x = rand_value(); it.pos_y = rand_value(); it.pos_z = rand_value();
        it.vel_x = rand_value(); it.vel_y = rand_value(); it.vel_z = rand_value();
        it.frc_x = rand_value(); it.frc_y = rand_value(); it.frc_z = rand_value();
        return it;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_particle(rand_particle());
        end
    endtask

    task automatic randomize_registers();
        write_reg(spu_pkg::REG_SHEAR_ROW_X, {rand_coef(), rand_coef(), rand_coef()});
        write_reg(spu_pkg::REG_SHEAR_ROW_Y, {rand_coef(), rand_coef(), rand_coef()});
        write_reg(spu_pkg::REG_SHEAR_ROW_Z, {rand_coef(), rand_coef(), rand_coef()});
        write_reg(spu_pkg::REG_REF_X, 48'(rand_value()));
        write_reg(spu_pkg::REG_REF_Y, 48'(rand_value()));
        write_reg(spu_pkg::REG_REF_Z, 48'(rand_value()));
        write_reg(spu_pkg::REG_TIME_STEP, 48'($urandom_range(65535)));
        write_reg(spu_pkg::REG_HALF_STEP_SQUARED, 48'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values of the registers, edge values of most fields
    task automatic test_directed_fields();
        spu_pkg::in_item_t it;
        for (int k = 0; k < 16; k++)
        begin
            it = '0;
            it.mode   = k[0];
            it.frozen = (k == 5 || k == 6);
            it.mass   = (k < 4) ? 16'd0 : ((k < 8) ? 16'hffff : 16'd256);
            it.pos_x  = k[1] ? 32'h7fffffff : 32'h80000000;
            it.pos_y  = 32'h00010000;
            it.pos_z  = k[2] ? 32'hffffffff : 32'h0;
            it.vel_x  = k[1] ? 32'h80000000 : 32'h7fffffff;
            it.vel_y  = 32'hfffe0000;
            it.vel_z  = k[3] ? 32'h7fffffff : 32'h1;
            it.frc_x  = k[2] ? 32'h7fffffff : 32'h80000000;
            it.frc_y  = k[3] ? 32'h80000000 : 32'h00100000;
            it.frc_z  = 32'hffffff00;
            send_particle(it);
        end
        drain_results();
    endtask

    // full-scale tensor and extreme steps, both modes, with saturation
    task automatic test_extreme_settings();
        spu_pkg::in_item_t it;
        write_reg(spu_pkg::REG_SHEAR_ROW_X, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(spu_pkg::REG_SHEAR_ROW_Y, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(spu_pkg::REG_SHEAR_ROW_Z, {16'h1000, 16'h0000, 16'hf000});
        write_reg(spu_pkg::REG_REF_X, 48'h0000_8000_0000);
        write_reg(spu_pkg::REG_REF_Y, 48'h0000_7fff_ffff);
        write_reg(spu_pkg::REG_REF_Z, 48'h0000_0000_0000);
        write_reg(spu_pkg::REG_TIME_STEP, 48'hffff);
        write_reg(spu_pkg::REG_HALF_STEP_SQUARED, 48'hffff_ffff);
        for (int k = 0; k < 8; k++)
        begin
            it = rand_particle();
            it.mode   = k[0];
            it.frozen = 1'b0;
            it.mass   = k[1] ? 16'hffff : 16'd1;
            send_particle(it);
        end
        drain_results();
        write_reg(spu_pkg::REG_TIME_STEP, 48'h0);
        write_reg(spu_pkg::REG_HALF_STEP_SQUARED, 48'h0);
    endtask

    // several random register settings with the given idle mix
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int count);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        for (int s = 0; s < 3; s++)
        begin
            randomize_registers();
            send_random(count / 3);
            drain_results();
        end
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input,
    // then a sender pause until every result is back, and a short second burst
    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_cycles  = 120;
        send_random(60);
        drain_results();
        send_random(10);
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = spu_pkg::REG_SHEAR_ROW_X;
        cfg_data       = '0;
        mismatches     = 0;
        results_seen   = 0;
        particles_sent = 0;
        send_gap_pct   = 0;
        recv_gap_pct   = 0;
        hold_cycles    = 0;
        tensor_rows    = '{default: '0};
        wall_ref       = '{default: '0};
        dt_reg         = spu_pkg::DT_RESET;
        hdt_reg        = spu_pkg::HDT_RESET;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_fields();
        test_extreme_settings();
        test_random_phase(8, 50, 420);
        test_random_phase(50, 8, 420);
        test_random_phase(0, 0, 420);
        test_backpressure();

        $display("covered %0d particles, %0d results: both modes, frozen, zero mass,",
                 particles_sent, results_seen);
        $display("saturation, extreme registers, idle mixes and a long output stall");
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("timeout waiting for results");
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hdl/spu_pkg.sv
hdl/spu_tensor_mac.sv
hdl/spu_floor_div.sv
hdl/sllod_particle_update.sv
bench/tb_sllod_particle_update.sv
